FILE: src/tcle_pkg.sv
// ----------------------------------------------------------------------------
// tcle_pkg
// Shared constants, request codes and helpers of the tiled convolution engine.
// ----------------------------------------------------------------------------
package tcle_pkg;

    localparam int TILE_OUT_CH_D = 4;
    localparam int TILE_IN_CH_D  = 4;
    localparam int TILE_ROWS_D   = 8;
    localparam int TILE_COLS_D   = 8;
    localparam int MAX_KERNEL_D  = 3;
    localparam int MAX_STRIDE_D  = 2;

    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;

    typedef enum logic [1:0] {
        REQ_WR_WEIGHT = 2'd0,
        REQ_WR_PIXEL  = 2'd1,
        REQ_COMPUTE   = 2'd2,
        REQ_READ      = 2'd3
    } t_req;

    localparam logic [2:0] ADDR_KSIZE  = 3'd0;
    localparam logic [2:0] ADDR_STRIDE = 3'd4;

    function automatic int f_w(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

endpackage

FILE: src/tcle_ram.sv
// ----------------------------------------------------------------------------
// tcle_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcle_ram
    import tcle_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [f_w(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic [f_w(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: src/tiled_conv_layer_engine_unit.sv
// ----------------------------------------------------------------------------
// tiled_conv_layer_engine_unit
// Convolution over one tile held in weight, pixel and accumulator RAMs.
// ----------------------------------------------------------------------------
// Requests arrive on a valid/stall channel: weight write, pixel write,
// compute and read. A read gives its result through the registered read
// port of the accumulator RAM and then an output register; the next request
// is taken once the read data has landed, so a new read is not taken while
// one is pending. A read outside the tile gives no result.
// A compute request holds o_stall high while the sequencer walks the tile:
// one multiply-accumulate per cycle, TILE_OUT_CH*TILE_ROWS*TILE_COLS*
// TILE_IN_CH*k*k multiply-accumulates per tile, and o_stall stays high until
// the pipeline behind the weight and pixel RAM read ports has drained. The
// accumulator RAM is read and written back once per output.
// Reset clears the valid bits of the accumulators at once (all read as zero),
// the registers kernel_size=3 and stride=1 and all control state. When the
// receiver stalls, the result holds in the output register and no further
// request is taken. Configuration goes over the APB port at 0 and 4.
// ----------------------------------------------------------------------------
module tiled_conv_layer_engine_unit
    import tcle_pkg::*;
#(
    parameter int TILE_OUT_CH = TILE_OUT_CH_D,
    parameter int TILE_IN_CH  = TILE_IN_CH_D,
    parameter int TILE_ROWS   = TILE_ROWS_D,
    parameter int TILE_COLS   = TILE_COLS_D,
    parameter int MAX_KERNEL  = MAX_KERNEL_D,
    parameter int MAX_STRIDE  = MAX_STRIDE_D
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_req_type,
    input  logic [1:0]              i_out_chan,
    input  logic [1:0]              i_in_chan,
    input  logic [1:0]              i_kernel_row,
    input  logic [1:0]              i_kernel_col,
    input  logic [4:0]              i_row,
    input  logic [4:0]              i_col,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_accumulate,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ACC_W-1:0] o_result_value,
    output logic [1:0]              o_res_chan,
    output logic [2:0]              o_res_row,
    output logic [2:0]              o_res_col
);

    localparam int IN_ROWS = (TILE_ROWS - 1) * MAX_STRIDE + MAX_KERNEL;
    localparam int IN_COLS = (TILE_COLS - 1) * MAX_STRIDE + MAX_KERNEL;
    localparam int W_D     = TILE_OUT_CH * TILE_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int P_D     = TILE_IN_CH * IN_ROWS * IN_COLS;
    localparam int A_D     = TILE_OUT_CH * TILE_ROWS * TILE_COLS;
    localparam int WA_W    = f_w(W_D);
    localparam int PA_W    = f_w(P_D);
    localparam int AA_W    = f_w(A_D);
    localparam int OC_W    = f_w(TILE_OUT_CH);
    localparam int IC_W    = f_w(TILE_IN_CH);
    localparam int R_W     = f_w(TILE_ROWS);
    localparam int C_W     = f_w(TILE_COLS);
    localparam int K_W     = f_w(MAX_KERNEL + 1);
    localparam int S_W     = f_w(MAX_STRIDE + 1);
    localparam int SUM_W   = PROD_W + f_w(TILE_IN_CH * MAX_KERNEL * MAX_KERNEL) + 1;
    localparam int EXT_W   = ((SUM_W > ACC_W) ? SUM_W : ACC_W) + 1;
    localparam int IR_W    = f_w(IN_ROWS) + 1;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state r_state;
    logic [1:0] r_ksize, r_stride;
    logic [K_W-1:0] r_k;
    logic [S_W-1:0] r_s;
    logic r_acc_mode;
    logic [OC_W-1:0] r_oc;
    logic [R_W-1:0]  r_r;
    logic [C_W-1:0]  r_c;
    logic [IC_W-1:0] r_ic;
    logic [K_W-1:0]  r_kr, r_kc;

    logic r_p1_vld, r_p1_first, r_p1_last, r_p1_avld;
    logic [AA_W-1:0] r_p1_aaddr;
    logic r_p2_vld, r_p2_first, r_p2_last;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_p2_old;
    logic [AA_W-1:0] r_p2_aaddr;
    logic r_p3_last;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ACC_W-1:0]  r_p3_old;
    logic [AA_W-1:0] r_p3_aaddr;

    logic r_rd_pend, r_rd_avld;
    logic [A_D-1:0] r_acc_vld;

    logic accept, busy, cfg_wr, term_first, term_last, tile_end;
    logic [K_W-1:0] k_clamp;
    logic [S_W-1:0] s_clamp;
    logic [WA_W-1:0] w_waddr, w_raddr;
    logic [PA_W-1:0] p_waddr, p_raddr;
    logic [AA_W-1:0] a_seq_addr, a_req_addr, a_raddr;
    logic [IR_W-1:0] in_r, in_c;
    logic w_we, p_we, rd_ok;
    logic signed [VAL_W-1:0] w_rdata, p_rdata;
    logic signed [ACC_W-1:0] a_rdata, acc_new;
    logic signed [EXT_W-1:0] ext_sum;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ADDR_KSIZE)  ? {30'd0, r_ksize} :
                    (paddr == ADDR_STRIDE) ? {30'd0, r_stride} : 32'd0;

    assign busy    = (r_state != S_IDLE) || r_p1_vld || r_p2_vld || r_p3_last;
    assign o_stall = busy || r_rd_pend || (o_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    assign k_clamp = (r_ksize == 2'd0) ? K_W'(1) :
                     ({30'd0, r_ksize} > 32'(MAX_KERNEL)) ? K_W'(MAX_KERNEL) : K_W'(r_ksize);
    assign s_clamp = (r_stride == 2'd0) ? S_W'(1) :
                     ({30'd0, r_stride} > 32'(MAX_STRIDE)) ? S_W'(MAX_STRIDE) : S_W'(r_stride);

    assign w_we = accept && (i_req_type == REQ_WR_WEIGHT)
                  && ({30'd0, i_out_chan} < 32'(TILE_OUT_CH))
                  && ({30'd0, i_in_chan} < 32'(TILE_IN_CH))
                  && ({30'd0, i_kernel_row} < 32'(MAX_KERNEL))
                  && ({30'd0, i_kernel_col} < 32'(MAX_KERNEL));
    assign p_we = accept && (i_req_type == REQ_WR_PIXEL)
                  && ({30'd0, i_in_chan} < 32'(TILE_IN_CH))
                  && ({27'd0, i_row} < 32'(IN_ROWS))
                  && ({27'd0, i_col} < 32'(IN_COLS));
    assign rd_ok = ({30'd0, i_out_chan} < 32'(TILE_OUT_CH))
                   && ({27'd0, i_row} < 32'(TILE_ROWS))
                   && ({27'd0, i_col} < 32'(TILE_COLS));

    assign w_waddr = WA_W'(((32'(i_out_chan) * TILE_IN_CH + 32'(i_in_chan)) * MAX_KERNEL
                           + 32'(i_kernel_row)) * MAX_KERNEL + 32'(i_kernel_col));
    assign p_waddr = PA_W'((32'(i_in_chan) * IN_ROWS + 32'(i_row)) * IN_COLS + 32'(i_col));
    assign a_req_addr = AA_W'((32'(i_out_chan) * TILE_ROWS + 32'(i_row)) * TILE_COLS
                              + 32'(i_col));

    assign in_r = IR_W'(32'(r_r) * 32'(r_s) + 32'(r_kr));
    assign in_c = IR_W'(32'(r_c) * 32'(r_s) + 32'(r_kc));
    assign w_raddr = WA_W'(((32'(r_oc) * TILE_IN_CH + 32'(r_ic)) * MAX_KERNEL + 32'(r_kr))
                           * MAX_KERNEL + 32'(r_kc));
    assign p_raddr = PA_W'((32'(r_ic) * IN_ROWS + 32'(in_r)) * IN_COLS + 32'(in_c));
    assign a_seq_addr = AA_W'((32'(r_oc) * TILE_ROWS + 32'(r_r)) * TILE_COLS + 32'(r_c));
    assign a_raddr = (r_state == S_RUN) ? a_seq_addr : a_req_addr;

    assign term_first = (r_ic == '0) && (r_kr == '0) && (r_kc == '0);
    assign term_last  = (32'(r_ic) == 32'(TILE_IN_CH - 1)) && (r_kr == r_k - K_W'(1))
                        && (r_kc == r_k - K_W'(1));
    assign tile_end   = term_last && (32'(r_oc) == 32'(TILE_OUT_CH - 1))
                        && (32'(r_r) == 32'(TILE_ROWS - 1))
                        && (32'(r_c) == 32'(TILE_COLS - 1));

    assign ext_sum = EXT_W'(r_sum) + EXT_W'(r_p3_old);
    assign acc_new = (ext_sum > EXT_W'(signed'({1'b0, {(ACC_W-1){1'b1}}}))) ?
                         {1'b0, {(ACC_W-1){1'b1}}} :
                     (ext_sum < EXT_W'(signed'({1'b1, {(ACC_W-1){1'b0}}}))) ?
                         {1'b1, {(ACC_W-1){1'b0}}} : ACC_W'(ext_sum);

    tcle_ram #(.WIDTH(VAL_W), .DEPTH(W_D)) u_wram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_value),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    tcle_ram #(.WIDTH(VAL_W), .DEPTH(P_D)) u_pram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(i_value),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    tcle_ram #(.WIDTH(ACC_W), .DEPTH(A_D)) u_aram (
        .i_clk(i_clk), .i_we(r_p3_last), .i_waddr(r_p3_aaddr), .i_wdata(acc_new),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ksize   <= 2'd3;
            r_stride  <= 2'd1;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_last <= 1'b0;
            r_rd_pend <= 1'b0;
            o_valid   <= 1'b0;
            r_acc_vld <= '0;
        end else begin
            if (cfg_wr && paddr == ADDR_KSIZE) begin
                r_ksize <= pwdata[1:0];
            end
            if (cfg_wr && paddr == ADDR_STRIDE) begin
                r_stride <= pwdata[1:0];
            end

            case (r_state)
                S_IDLE: begin
                    if (accept && i_req_type == REQ_COMPUTE) begin
                        r_state    <= S_RUN;
                        r_k        <= k_clamp;
                        r_s        <= s_clamp;
                        r_acc_mode <= i_accumulate;
                        r_oc <= '0; r_r <= '0; r_c <= '0;
                        r_ic <= '0; r_kr <= '0; r_kc <= '0;
                    end
                end
                S_RUN: begin
                    if (r_kc != r_k - K_W'(1)) begin
                        r_kc <= r_kc + K_W'(1);
                    end else begin
                        r_kc <= '0;
                        if (r_kr != r_k - K_W'(1)) begin
                            r_kr <= r_kr + K_W'(1);
                        end else begin
                            r_kr <= '0;
                            if (32'(r_ic) != 32'(TILE_IN_CH - 1)) begin
                                r_ic <= r_ic + IC_W'(1);
                            end else begin
                                r_ic <= '0;
                                if (32'(r_c) != 32'(TILE_COLS - 1)) begin
                                    r_c <= r_c + C_W'(1);
                                end else begin
                                    r_c <= '0;
                                    if (32'(r_r) != 32'(TILE_ROWS - 1)) begin
                                        r_r <= r_r + R_W'(1);
                                    end else begin
                                        r_r  <= '0;
                                        r_oc <= r_oc + OC_W'(1);
                                    end
                                end
                            end
                        end
                    end
                    if (tile_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            r_p1_vld  <= (r_state == S_RUN);
            r_p2_vld  <= r_p1_vld;
            r_p3_last <= r_p2_vld && r_p2_last;
            if (r_p3_last) begin
                r_acc_vld[r_p3_aaddr] <= 1'b1;
            end

            r_rd_pend <= accept && (i_req_type == REQ_READ) && rd_ok;
            if (r_rd_pend) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_first <= term_first;
        r_p1_last  <= term_last;
        r_p1_aaddr <= a_raddr;
        r_p1_avld  <= r_acc_vld[a_raddr];
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_aaddr <= r_p1_aaddr;
        r_prod     <= PROD_W'(w_rdata * p_rdata);
        r_p2_old   <= (r_p1_avld && r_acc_mode) ? a_rdata : '0;
        if (r_p2_vld) begin
            r_sum <= r_p2_first ? SUM_W'(r_prod) : r_sum + SUM_W'(r_prod);
        end
        r_p3_old   <= r_p2_old;
        r_p3_aaddr <= r_p2_aaddr;
        if (accept) begin
            o_res_chan <= i_out_chan;
            o_res_row  <= i_row[2:0];
            o_res_col  <= i_col[2:0];
        end
        r_rd_avld <= r_acc_vld[a_raddr];
        if (r_rd_pend) begin
            o_result_value <= r_rd_avld ? a_rdata : '0;
        end
    end

endmodule

FILE: src/tcle_chk.sv
// ----------------------------------------------------------------------------
// tcle_chk
// Port-level checks of the tiled convolution engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcle_chk
    import tcle_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic [1:0]              i_req_type,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [ACC_W-1:0] o_result_value
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value))
        else $error("result dropped or changed under stall");

    a_compute_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req_type == REQ_COMPUTE |=> o_stall)
        else $error("request taken while tile compute runs");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_req_type == REQ_READ, 2))
        else $error("result without a read request");

    a_read_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("request taken before read data landed");

endmodule

bind tiled_conv_layer_engine_unit tcle_chk u_tcle_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_req_type(i_req_type), .o_valid(o_valid), .i_stall(i_stall),
    .o_result_value(o_result_value)
);

FILE: tb/sv/tb_tiled_conv_layer_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_tiled_conv_layer_engine_unit
// Self-checking bench for the tiled convolution engine: loads weight and pixel
// tiles, runs compute requests at several kernel settings, reads back
// accumulators and compares them with a local predictor of the tile.
// ----------------------------------------------------------------------------
module tb_tiled_conv_layer_engine_unit;
    import tcle_pkg::*;

    localparam int OC_N = TILE_OUT_CH_D;
    localparam int IC_N = TILE_IN_CH_D;
    localparam int TR_N = TILE_ROWS_D;
    localparam int TC_N = TILE_COLS_D;
    localparam int MK = MAX_KERNEL_D;
    localparam int MS = MAX_STRIDE_D;
    localparam int IR_N = (TR_N - 1) * MS + MK;
    localparam int ICL_N = (TC_N - 1) * MS + MK;
    localparam int PR_N = TR_N - 1 + MK;
    localparam int PC_N = TC_N - 1 + MK;
    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct {
        logic [ACC_W-1:0] value;
        logic [1:0] chan;
        logic [2:0] row;
        logic [2:0] col;
    } t_acc_read;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_req_type = '0, i_out_chan = '0, i_in_chan = '0;
    logic [1:0] i_kernel_row = '0, i_kernel_col = '0;
    logic [4:0] i_row = '0, i_col = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic i_accumulate = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [ACC_W-1:0] o_result_value;
    logic [1:0] o_res_chan;
    logic [2:0] o_res_row, o_res_col;

    tiled_conv_layer_engine_unit u_top (.*);

    logic signed [15:0] wt_mem [OC_N][IC_N][MK][MK];
    logic signed [15:0] px_mem [IC_N][IR_N][ICL_N];
    longint acc_mem [OC_N][TR_N][TC_N];
    int ksize_reg = 3, stride_reg = 1;
    t_acc_read pending_reads[$];
    int err_count = 0, reads_seen = 0, computes_sent = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic longint sat_acc(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic void predict_tile(input logic acc);
        int k, s;
        longint sum;
        k = (ksize_reg < 1) ? 1 : (ksize_reg > MK) ? MK : ksize_reg;
        s = (stride_reg < 1) ? 1 : (stride_reg > MS) ? MS : stride_reg;
        for (int oc = 0; oc < OC_N; oc++)
            for (int r = 0; r < TR_N; r++)
                for (int c = 0; c < TC_N; c++) begin
                    sum = 0;
                    for (int ic = 0; ic < IC_N; ic++)
                        for (int kr = 0; kr < k; kr++)
                            for (int kc = 0; kc < k; kc++)
                                sum += longint'(wt_mem[oc][ic][kr][kc]) *
                                       longint'(px_mem[ic][r*s+kr][c*s+kc]);
                    acc_mem[oc][r][c] = acc ? sat_acc(acc_mem[oc][r][c] + sum)
                                            : sat_acc(sum);
                end
    endfunction

    function automatic void predict_request(input t_req rt, input int oc, input int ic,
                                            input int kr, input int kc, input int r,
                                            input int c, input logic signed [15:0] v,
                                            input logic acc);
        t_acc_read e;
        case (rt)
            REQ_WR_WEIGHT: begin
                if (oc < OC_N && ic < IC_N && kr < MK && kc < MK) wt_mem[oc][ic][kr][kc] = v;
            end
            REQ_WR_PIXEL: begin
                if (ic < IC_N && r < IR_N && c < ICL_N) px_mem[ic][r][c] = v;
            end
            REQ_COMPUTE: begin
                predict_tile(acc);
            end
            default: begin
                if (oc < OC_N && r < TR_N && c < TC_N) begin
                    e.value = acc_mem[oc][r][c][ACC_W-1:0];
                    e.chan = 2'(oc);
                    e.row = 3'(r);
                    e.col = 3'(c);
                    pending_reads.push_back(e);
                end
            end
        endcase
    endfunction

    task automatic send_request(input t_req rt, input int oc, input int ic, input int kr,
                                input int kc, input int r, input int c,
                                input logic signed [15:0] v, input logic acc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rt;
        i_out_chan <= 2'(oc);
        i_in_chan <= 2'(ic);
        i_kernel_row <= 2'(kr);
        i_kernel_col <= 2'(kc);
        i_row <= 5'(r);
        i_col <= 5'(c);
        i_value <= v;
        i_accumulate <= acc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_request(rt, oc, ic, kr, kc, r, c, v, acc);
        if (rt == REQ_COMPUTE) computes_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input int val);
        drain_results();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_KSIZE) ksize_reg = val & 3;
        else ksize_reg = ksize_reg;
        if (addr == ADDR_STRIDE) stride_reg = val & 3;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    task automatic load_tiles();
        for (int oc = 0; oc < OC_N; oc++)
            for (int ic = 0; ic < IC_N; ic++)
                for (int kr = 0; kr < MK; kr++)
                    for (int kc = 0; kc < MK; kc++)
                        send_request(REQ_WR_WEIGHT, oc, ic, kr, kc, 0, 0,
                                     rand_value(), 1'b0);
        for (int ic = 0; ic < IC_N; ic++)
            for (int r = 0; r < PR_N; r++)
                for (int c = 0; c < PC_N; c++)
                    send_request(REQ_WR_PIXEL, 0, ic, 0, 0, r, c, rand_value(), 1'b0);
    endtask

    task automatic random_reads(input int n);
        for (int i = 0; i < n; i++)
            send_request(REQ_READ, $urandom_range(3), $urandom_range(3), $urandom_range(3),
                         $urandom_range(3), $urandom_range(9), $urandom_range(9),
                         16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
            if (o_valid && !i_stall) begin
                reads_seen++;
                if (pending_reads.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_result_value), 64'd0);
                end else begin
                    if (o_result_value !== pending_reads[0].value)
                        report_mismatch("value", 64'(o_result_value),
                                        64'(pending_reads[0].value));
                    if (o_res_chan !== pending_reads[0].chan)
                        report_mismatch("chan", 64'(o_res_chan), 64'(pending_reads[0].chan));
                    if (o_res_row !== pending_reads[0].row)
                        report_mismatch("row", 64'(o_res_row), 64'(pending_reads[0].row));
                    if (o_res_col !== pending_reads[0].col)
                        report_mismatch("col", 64'(o_res_col), 64'(pending_reads[0].col));
                    void'(pending_reads.pop_front());
                end
            end
        end
    end

    task automatic test_reset_reads();
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(REQ_READ, 3, 0, 0, 0, 7, 7, 0, 1'b0);
        send_request(REQ_READ, 0, 0, 0, 0, 8, 0, 0, 1'b0);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 31, 0, 1'b0);
    endtask

    task automatic test_ignored_writes();
        send_request(REQ_WR_WEIGHT, 0, 0, 3, 0, 0, 0, 16'sh1234, 1'b0);
        send_request(REQ_WR_WEIGHT, 0, 0, 0, 3, 0, 0, 16'sh1234, 1'b0);
        send_request(REQ_WR_PIXEL, 0, 0, 0, 0, IR_N, 0, 16'sh1234, 1'b0);
        send_request(REQ_WR_PIXEL, 0, 0, 0, 0, 0, 31, 16'sh1234, 1'b0);
    endtask

    task automatic test_load();
        load_tiles();
    endtask

    task automatic test_compute_phase(input int k, input int s, input int n_reads);
        write_reg(ADDR_KSIZE, k);
        write_reg(ADDR_STRIDE, s);
        send_request(REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        random_reads(n_reads);
        send_request(REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        random_reads(n_reads);
    endtask

    task automatic test_saturation();
        write_reg(ADDR_KSIZE, 3);
        write_reg(ADDR_STRIDE, 1);
        for (int ic = 0; ic < IC_N; ic++)
            for (int kr = 0; kr < MK; kr++)
                for (int kc = 0; kc < MK; kc++)
                    send_request(REQ_WR_PIXEL, 0, ic, 0, 0, kr, kc,
                                 (wt_mem[0][ic][kr][kc] < 0) ? 16'sh8000 : 16'sh7FFF,
                                 1'b0);
        for (int i = 0; i < 200 && acc_mem[0][0][0] != ACC_HI; i++)
            send_request(REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send_request(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_request(REQ_READ, 3, 0, 0, 0, 7, 7, 0, 1'b0);
    endtask

    task automatic test_out_of_range_regs();
        write_reg(ADDR_KSIZE, 0);
        write_reg(ADDR_STRIDE, 0);
        send_request(REQ_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        random_reads(6);
        drain_results();
        send_request(REQ_READ, 1, 0, 0, 0, 2, 3, 0, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_reads();
        test_ignored_writes();
        test_load();
        test_compute_phase(3, 1, 6);
        send_idle_pct = 80;
        test_compute_phase(1, 1, 6);
        send_idle_pct = 0;
        recv_stall_pct = 80;
        test_compute_phase(2, 1, 6);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        test_compute_phase(3, 1, 6);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_out_of_range_regs();
        test_saturation();
        drain_results();
        repeat (20) @(posedge i_clk);
        $display("covered %0d computes and %0d accumulator reads over kernel 0..3,",
                 computes_sent, reads_seen);
        $display("stride 0..1, saturation, ignored writes and four idling mixes");
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
